FILE: src/autocalibrating_axis_scaler_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the axis scaler
// Each macro expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef AUTOCALIBRATING_AXIS_SCALER_UNIT_ASSERT_SVH
`define AUTOCALIBRATING_AXIS_SCALER_UNIT_ASSERT_SVH

// Same-cycle implication
`define ASU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("axis scaler check failed");

// Next-cycle implication
`define ASU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("axis scaler check failed");

`endif

FILE: src/asu_pkg.sv
// ----------------------------------------------------------------------------
// asu_pkg
// Shared types and constants of the auto-ranging axis scaler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package asu_pkg;

    localparam int SAMPLE_W = 12;
    localparam int VAL_W    = 8;

    // Operation codes carried in tuser
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_LOAD   = 1'b1;

    // Calibration range after reset
    localparam logic [VAL_W-1:0] RANGE_MIN_RST = 8'd0;
    localparam logic [VAL_W-1:0] RANGE_MAX_RST = 8'd254;

    typedef struct packed {
        logic accept;    // capture request, filter and widen
        logic mul;       // form product and span, seed divider
        logic div_step;  // one restoring division step
        logic out_load;  // write the result register
    } asu_cmd_t;

    typedef struct packed {
        logic out_valid; // result register holds an untaken result
    } asu_sts_t;

endpackage

FILE: src/asu_ctrl.sv
// ----------------------------------------------------------------------------
// asu_ctrl
// Sequencer: accept, multiply, eight divider steps, result write; a load goes from accept to the result write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asu_ctrl
    import asu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_axis_tvalid,
    output logic     s_axis_tready,
    input  logic     op,
    input  logic     m_axis_tready,
    input  asu_sts_t sts,
    output asu_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    localparam logic [2:0] LAST_STEP = 3'd7;

    logic [1:0] state_reg, state_next;
    logic [2:0] step_reg, step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = (op == OP_LOAD) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                step_next  = 3'd0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 3'd1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // hold until the result register frees up
                if (!sts.out_valid || m_axis_tready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/asu_dpath.sv
// ----------------------------------------------------------------------------
// asu_dpath
// Filter, range tracking, multiplier, restoring divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module asu_dpath
    import asu_pkg::*;
#(
    parameter int FULL_SCALE = 254
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  asu_cmd_t            cmd,
    output asu_sts_t            sts,
    input  logic                op,
    input  logic [SAMPLE_W-1:0] adc_sample,
    input  logic [VAL_W-1:0]    cal_min_in,
    input  logic [VAL_W-1:0]    cal_max_in,
    input  logic                cfg_valid,
    input  logic                cfg_data,
    input  logic                m_axis_tready,
    output logic                m_axis_tvalid,
    output logic [VAL_W-1:0]    axis_value,
    output logic                widened,
    output logic [VAL_W-1:0]    cal_min_out,
    output logic [VAL_W-1:0]    cal_max_out
);

    localparam logic [VAL_W-1:0] FS = FULL_SCALE[VAL_W-1:0];

    logic                 reverse_reg;
    logic [VAL_W-1:0]     prev_reg, prev_next;
    logic [VAL_W-1:0]     min_reg, min_next;
    logic [VAL_W-1:0]     max_reg, max_next;
    logic [VAL_W-1:0]     v_reg;
    logic                 load_reg;
    logic                 wide_reg, wide_next;
    logic [VAL_W-1:0]     span_reg;
    logic                 empty_reg;
    logic [VAL_W-1:0]     rem_reg, rem_next;
    logic [VAL_W-1:0]     quo_reg, quo_next;
    logic                 out_valid_reg;
    logic [VAL_W-1:0]     axis_reg, axis_next;
    logic                 owide_reg;
    logic [VAL_W-1:0]     omin_reg;
    logic [VAL_W-1:0]     omax_reg;

    logic [VAL_W:0]       filt_sum;
    logic [VAL_W-1:0]     filt;
    logic [VAL_W-1:0]     diff;
    logic [2*VAL_W-1:0]   prod;
    logic [VAL_W:0]       trial;
    logic [VAL_W:0]       trial_sub;

    // filter and widening, evaluated on the incoming request
    always_comb
    begin
        filt_sum  = {1'b0, adc_sample[SAMPLE_W-1 -: VAL_W]} + {1'b0, prev_reg};
        filt      = filt_sum[VAL_W:1];
        prev_next = prev_reg;
        min_next  = min_reg;
        max_next  = max_reg;
        wide_next = 1'b0;
        if (op == OP_SAMPLE)
        begin
            prev_next = filt;
            if (filt < min_reg)
            begin
                min_next  = filt;
                wide_next = 1'b1;
            end
            if (filt > max_reg)
            begin
                max_next  = filt;
                wide_next = 1'b1;
            end
        end
        else
        begin
            min_next = cal_min_in;
            max_next = cal_max_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reverse_reg <= 1'b0;
            prev_reg    <= '0;
            min_reg     <= RANGE_MIN_RST;
            max_reg     <= RANGE_MAX_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                reverse_reg <= cfg_data;
            end
            if (cmd.accept)
            begin
                prev_reg <= prev_next;
                min_reg  <= min_next;
                max_reg  <= max_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            v_reg    <= filt;
            load_reg <= (op == OP_LOAD);
            wide_reg <= wide_next;
        end
    end

    // widening leaves min <= v <= max, so both differences are non-negative
    assign diff = v_reg - min_reg;
    assign prod = {{VAL_W{1'b0}}, diff} * {{VAL_W{1'b0}}, FS};

    // quotient fits in 8 bits, so the top byte of the product seeds the remainder
    always_comb
    begin
        trial     = {rem_reg, quo_reg[VAL_W-1]};
        trial_sub = trial - {1'b0, span_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (cmd.mul)
        begin
            rem_next = prod[2*VAL_W-1:VAL_W];
            quo_next = prod[VAL_W-1:0];
        end
        else if (cmd.div_step)
        begin
            if (trial >= {1'b0, span_reg})
            begin
                rem_next = trial_sub[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            span_reg  <= max_reg - min_reg;
            empty_reg <= (max_reg == min_reg);
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    always_comb
    begin
        if (load_reg || empty_reg)
        begin
            axis_next = '0;
        end
        else if (reverse_reg)
        begin
            axis_next = FS - quo_reg;
        end
        else
        begin
            axis_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            axis_reg  <= axis_next;
            owide_reg <= wide_reg & ~load_reg;
            omin_reg  <= min_reg;
            omax_reg  <= max_reg;
        end
    end

    assign sts.out_valid = out_valid_reg;
    assign m_axis_tvalid = out_valid_reg;
    assign axis_value    = axis_reg;
    assign widened       = owide_reg;
    assign cal_min_out   = omin_reg;
    assign cal_max_out   = omax_reg;

endmodule

FILE: src/autocalibrating_axis_scaler_unit.sv
// ----------------------------------------------------------------------------
// autocalibrating_axis_scaler_unit
// Each request is either a converter sample or a calibration load. A sample
// is cut to 8 bits, averaged with the last filtered value, widens the
// calibration range if it falls outside it, and is mapped onto
// 0..FULL_SCALE (reversed when the config bit is set); a load writes the
// range and returns 0. Every result carries the range after the request.
// A sample passes filtering and widening, the 8x8 multiply, eight steps
// of the restoring divider at one quotient bit per cycle, and the result
// register write, which waits while an earlier result is stalled; a load
// skips from accept to the write. A new request is accepted the cycle after
// the result register is written, even while that result waits for m_axis_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module autocalibrating_axis_scaler_unit
    import asu_pkg::*;
#(
    parameter int FULL_SCALE = 254
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // adc_sample[11:0], cal_min_in[19:12], cal_max_in[27:20]
    input  logic        s_axis_tuser,  // operation[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // axis_value[7:0], cal_min_out[15:8], cal_max_out[23:16]
    output logic        m_axis_tuser,  // widened[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data       // reverse_axis
);

    asu_cmd_t         cmd;
    asu_sts_t         sts;
    logic [VAL_W-1:0] axis_value;
    logic [VAL_W-1:0] cal_min_out;
    logic [VAL_W-1:0] cal_max_out;

    assign cfg_ready = 1'b1;

    asu_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .op            (s_axis_tuser),
        .m_axis_tready (m_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    asu_dpath #(
        .FULL_SCALE (FULL_SCALE)
    ) u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (s_axis_tuser),
        .adc_sample    (s_axis_tdata[11:0]),
        .cal_min_in    (s_axis_tdata[19:12]),
        .cal_max_in    (s_axis_tdata[27:20]),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .axis_value    (axis_value),
        .widened       (m_axis_tuser),
        .cal_min_out   (cal_min_out),
        .cal_max_out   (cal_max_out)
    );

    assign m_axis_tdata = {cal_max_out, cal_min_out, axis_value};

endmodule

FILE: src/asu_checker.sv
// ----------------------------------------------------------------------------
// asu_checker
// Port-level checks of the axis scaler, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "autocalibrating_axis_scaler_unit_assert.svh"

module asu_checker #(
    parameter int FULL_SCALE = 254
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    // a stalled result holds
    `ASU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // the block is not ready in the cycle after it takes a request
    `ASU_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // scaled value never passes full scale
    `ASU_ASSERT_NOW(a_axis_bound, m_axis_tvalid, m_axis_tdata[7:0] <= FULL_SCALE)

    // a widening sample leaves an ordered range
    `ASU_ASSERT_NOW(a_widened_order, m_axis_tvalid && m_axis_tuser, m_axis_tdata[15:8] <= m_axis_tdata[23:16])

endmodule

bind autocalibrating_axis_scaler_unit asu_checker #(
    .FULL_SCALE (FULL_SCALE)
) u_asu_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
